// File: rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// concurrent assertion helpers, empty when SYNTHESIS is defined
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// expression holds at every clock edge outside reset
`define ASSERT_ALWAYS(lbl, clk, rst, expr) \
   lbl: assert property (@(posedge clk) disable iff (rst) (expr)) \
      else $error("assertion failed");

// consequent holds in the same cycle as the antecedent
`define ASSERT_IMPLIES(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// consequent holds in the cycle after the antecedent
`define ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`else

`define ASSERT_ALWAYS(lbl, clk, rst, expr)
`define ASSERT_IMPLIES(lbl, clk, rst, ante, cons)
`define ASSERT_NEXT(lbl, clk, rst, ante, cons)

`endif

`endif

// File: rtl/csq_pkg.sv
// ----------------------------------------------------------------------------
// csq_pkg
// types, constants and helpers of the charge status qualifier
// ----------------------------------------------------------------------------
package csq_pkg;

   localparam int unsigned CNT_W   = 8;
   localparam int unsigned LIMIT_W = 8;
   localparam int unsigned INDEX_W = 1;

   typedef logic [CNT_W-1:0]   cnt_type;
   typedef logic [LIMIT_W-1:0] limit_type;

   typedef enum logic [1:0] {
      MODE_IDLE     = 2'd0,
      MODE_CHARGING = 2'd1,
      MODE_CHARGED  = 2'd2
   } mode_type;

   typedef enum logic [INDEX_W-1:0] {
      CSR_CHARGE_LIMIT  = 1'b0,
      CSR_RELEASE_LIMIT = 1'b1
   } csr_index_type;

   localparam limit_type CHARGE_LIMIT_RST  = LIMIT_W'(12);
   localparam limit_type RELEASE_LIMIT_RST = LIMIT_W'(35);
   localparam cnt_type   CNT_MAX           = '1;

   // saturating increment
   function automatic cnt_type sat_inc(input cnt_type v);
      return (v == CNT_MAX) ? v : cnt_type'(v + cnt_type'(1));
   endfunction

endpackage

// File: rtl/charge_status_qualifier_core.sv
// ----------------------------------------------------------------------------
// charge_status_qualifier_core: active-low charger pin debounce state machine
// rsp valid comes from the req accepting edge via the input reg, then the result reg
// throughput 1 item per cycle while rsp_stall does not hold the result reg, set by the state update loop
// sync reset: idle, counters zero, limits 12 and 35, both channels empty
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module charge_status_qualifier_core
   import csq_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   // input item channel
   input  logic                req_valid,
   output logic                req_stall,
   input  logic                req_pin_level,
   // result item channel
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [1:0]          rsp_charge_state,
   output logic                rsp_connected,
   output logic                rsp_change_pulse,
   output logic                rsp_stop_polling,
   // configuration writes
   input  logic                csr_wr_en,
   input  logic [INDEX_W-1:0]  csr_index,
   input  logic [LIMIT_W-1:0]  csr_wdata
);

   // configuration registers
   limit_type charge_limit_ff;
   limit_type release_limit_ff;

   // input register stage
   logic      in_valid_ff;
   logic      in_pin_ff;

   // qualifier state
   mode_type  mode_ff, mode_in;
   cnt_type   low_ff, low_in;
   cnt_type   high_ff, high_in;
   logic      conn_ff, conn_in;

   // result register stage
   logic      out_valid_ff;
   mode_type  out_mode_ff;
   logic      out_conn_ff;
   logic      out_pulse_ff;
   logic      out_stop_ff;

   logic      out_free;
   logic      step;
   logic      pulse;
   logic      stop;
   cnt_type   low_inc;
   cnt_type   high_inc;

   // result register can take a new item when empty or being drained
   assign out_free  = !out_valid_ff || !rsp_stall;
   // input stage hands its item to the result stage
   assign step      = in_valid_ff && out_free;
   // input register is refilled in the same cycle it is emptied
   assign req_stall = in_valid_ff && !out_free;

   // ---------------------------------------------------------------------
   // configuration
   // ---------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         charge_limit_ff  <= CHARGE_LIMIT_RST;
         release_limit_ff <= RELEASE_LIMIT_RST;
      end else if (csr_wr_en) begin
         unique case (csr_index_type'(csr_index))
            CSR_CHARGE_LIMIT:  charge_limit_ff  <= csr_wdata;
            CSR_RELEASE_LIMIT: release_limit_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // ---------------------------------------------------------------------
   // input register
   // ---------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (!req_stall) begin
         in_valid_ff <= req_valid;
      end
   end

   // payload, no reset needed
   always_ff @(posedge clock) begin
      if (!req_stall && req_valid) begin
         in_pin_ff <= req_pin_level;
      end
   end

   // ---------------------------------------------------------------------
   // next state and per-item outputs
   // ---------------------------------------------------------------------
   always_comb begin
      mode_in  = mode_ff;
      low_in   = low_ff;
      high_in  = high_ff;
      conn_in  = conn_ff;
      pulse    = 1'b0;
      stop     = 1'b0;
      low_inc  = sat_inc(low_ff);
      high_inc = sat_inc(high_ff);

      unique case (mode_ff)
         MODE_CHARGING: begin
            if (!in_pin_ff) begin
               // low run, may qualify as charged
               high_in = '0;
               if (low_inc > charge_limit_ff) begin
                  mode_in = MODE_CHARGED;
                  low_in  = '0;
               end else begin
                  low_in = low_inc;
               end
            end else begin
               // high run, may fall back to idle
               low_in = '0;
               if (high_inc > charge_limit_ff) begin
                  mode_in = MODE_IDLE;
                  high_in = '0;
                  conn_in = 1'b0;
                  stop    = 1'b1;
               end else begin
                  high_in = high_inc;
               end
            end
         end
         MODE_CHARGED: begin
            low_in = '0;
            if (in_pin_ff) begin
               // release after a long high run
               if (high_inc > release_limit_ff) begin
                  mode_in = MODE_IDLE;
                  high_in = '0;
                  conn_in = 1'b0;
                  stop    = 1'b1;
               end else begin
                  high_in = high_inc;
               end
            end else begin
               high_in = '0;
            end
         end
         default: begin
            // idle, and the unused code treated as idle
            if (!in_pin_ff) begin
               pulse   = 1'b1;
               low_in  = low_inc;
               conn_in = 1'b1;
               mode_in = MODE_CHARGING;
            end else begin
               mode_in = MODE_IDLE;
               low_in  = '0;
               high_in = '0;
               conn_in = 1'b0;
               stop    = 1'b1;
            end
         end
      endcase
   end

   // state registers advance once per item
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_IDLE;
         low_ff  <= '0;
         high_ff <= '0;
         conn_ff <= 1'b0;
      end else if (step) begin
         mode_ff <= mode_in;
         low_ff  <= low_in;
         high_ff <= high_in;
         conn_ff <= conn_in;
      end
   end

   // ---------------------------------------------------------------------
   // result register
   // ---------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (out_free) begin
         out_valid_ff <= in_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (step) begin
         out_mode_ff  <= mode_in;
         out_conn_ff  <= conn_in;
         out_pulse_ff <= pulse;
         out_stop_ff  <= stop;
      end
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_charge_state = out_mode_ff;
   assign rsp_connected    = out_conn_ff;
   assign rsp_change_pulse = out_pulse_ff;
   assign rsp_stop_polling = out_stop_ff;

   // ---------------------------------------------------------------------
   // assertions
   // ---------------------------------------------------------------------
   // connect flag tracks exactly the non-idle states
   `ASSERT_ALWAYS(a_conn_mode, clock, reset, conn_ff == (mode_ff != MODE_IDLE))
   // change pulse only on entry to charging with supply connected
   `ASSERT_IMPLIES(a_pulse, clock, reset, out_valid_ff && out_pulse_ff, (out_mode_ff == MODE_CHARGING) && out_conn_ff)
   // stop request only ever ends in idle, disconnected
   `ASSERT_IMPLIES(a_stop, clock, reset, out_valid_ff && out_stop_ff, (out_mode_ff == MODE_IDLE) && !out_conn_ff)
   // input side stalls only when both stages are full
   `ASSERT_IMPLIES(a_stall, clock, reset, req_stall, in_valid_ff && out_valid_ff && rsp_stall)
   // a stalled result stays in the result register
   `ASSERT_NEXT(a_hold, clock, reset, out_valid_ff && rsp_stall, out_valid_ff && $stable(out_mode_ff))

endmodule
